FILE: design/lcdcd_pkg.sv
// Shared constants, types and command classification for the LCD command decoder.
package lcdcd_pkg;

  localparam int COLUMNS = 84;
  localparam int BANKS   = 6;

  localparam logic [6:0] COL_LAST  = 7'(COLUMNS - 1);
  localparam logic [2:0] BANK_LAST = 3'(BANKS - 1);
  localparam logic [7:0] COL_LIMIT = 8'(COLUMNS);
  localparam logic [5:0] BANK_LIMIT = 6'(BANKS);

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TEMP,
    CMD_BIAS,
    CMD_FUNC,
    CMD_DISP,
    CMD_YADDR,
    CMD_XADDR,
    CMD_RSVD
  } cmd_class_t;

  typedef struct packed {
    logic       ram_write;
    logic [6:0] ram_column;
    logic [2:0] ram_bank;
    logic [7:0] ram_data;
    logic       powered_down;
    logic       vertical_mode;
    logic       extended_set;
    logic [1:0] display_mode;
    logic [1:0] temp_coeff;
    logic [2:0] bias_level;
    logic [6:0] operating_voltage;
    logic       ignored;
  } result_t;

  // Commands are classified by the highest set bit of the byte.
  function automatic cmd_class_t cmd_class(logic [7:0] b);
    cmd_class_t c;
    if (b[7]) begin
      c = CMD_XADDR;
    end else if (b[6]) begin
      c = CMD_YADDR;
    end else if (b[5]) begin
      c = CMD_FUNC;
    end else if (b[4]) begin
      c = CMD_BIAS;
    end else if (b[3]) begin
      c = CMD_DISP;
    end else if (b[2]) begin
      c = CMD_TEMP;
    end else if (b == 8'h00) begin
      c = CMD_NOP;
    end else begin
      c = CMD_RSVD;
    end
    return c;
  endfunction

endpackage

FILE: design/lcdcd_in_if.sv
// Input channel carrying one SPI frame per beat.
interface lcdcd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] frame_byte;

  modport source (output valid, output operation, output frame_byte, input ready);
  modport sink (input valid, input operation, input frame_byte, output ready);
endinterface

FILE: design/lcdcd_out_if.sv
// Output channel carrying one decode result per beat.
interface lcdcd_out_if;
  logic       valid;
  logic       ready;
  logic       ram_write;
  logic [6:0] ram_column;
  logic [2:0] ram_bank;
  logic [7:0] ram_data;
  logic       powered_down;
  logic       vertical_mode;
  logic       extended_set;
  logic [1:0] display_mode;
  logic [1:0] temp_coeff;
  logic [2:0] bias_level;
  logic [6:0] operating_voltage;
  logic       ignored;

  modport source (
    output valid, output ram_write, output ram_column, output ram_bank, output ram_data,
    output powered_down, output vertical_mode, output extended_set, output display_mode,
    output temp_coeff, output bias_level, output operating_voltage, output ignored,
    input ready
  );
  modport sink (
    input valid, input ram_write, input ram_column, input ram_bank, input ram_data,
    input powered_down, input vertical_mode, input extended_set, input display_mode,
    input temp_coeff, input bias_level, input operating_voltage, input ignored,
    output ready
  );
endinterface

FILE: design/lcd_controller_command_decoder_unit.sv
// Top level of the LCD controller command decoder.
// Each input beat is one SPI frame, a command byte or a display data byte, and produces
// exactly one result beat with the RAM write (if any) and the controller settings after
// that frame. A frame is registered in the input register on acceptance, then decoded and
// applied to the controller state as its result is loaded into the result register.
// One frame per clock cycle is sustained while the result sink does not stall.
// Both sides may stall freely.
module lcd_controller_command_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  lcdcd_in_if.sink    cmd_in,
  lcdcd_out_if.source res_out
);
  import lcdcd_pkg::*;

  logic       s1_valid;
  logic       s1_operation;
  logic [7:0] s1_frame_byte;
  logic       s2_ready;
  logic       fire;
  result_t    dec_res;

  assign fire = s1_valid && s2_ready;

  lcdcd_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .cmd_in     (cmd_in),
    .valid      (s1_valid),
    .take       (s2_ready),
    .operation  (s1_operation),
    .frame_byte (s1_frame_byte)
  );

  lcdcd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .operation  (s1_operation),
    .frame_byte (s1_frame_byte),
    .res        (dec_res)
  );

  lcdcd_output_stage u_output (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid),
    .load_ready (s2_ready),
    .load_res   (dec_res),
    .res_out    (res_out)
  );

`ifndef NO_ASSERTIONS
  a_write_not_ignored: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.ram_write |-> !res_out.ignored)
    else $error("RAM write beat flagged as ignored");

  a_address_in_range: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res_out.ram_write |->
      ({1'b0, res_out.ram_column} < COL_LIMIT) && ({3'b000, res_out.ram_bank} < BANK_LIMIT))
    else $error("RAM write address out of range");

  a_command_no_address: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ram_write |->
      (res_out.ram_column == 7'd0) && (res_out.ram_bank == 3'd0) && (res_out.ram_data == 8'd0))
    else $error("Command beat carries RAM address or data");

  a_decode_on_fire: assert property (@(posedge clk) disable iff (rst)
    fire |=> res_out.valid)
    else $error("Decoded beat did not reach the result register");
`endif

endmodule

FILE: design/lcdcd_decode.sv
// Controller state registers, command decode and address counter update.
module lcdcd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              operation,
  input  logic [7:0]        frame_byte,
  output lcdcd_pkg::result_t res
);
  import lcdcd_pkg::*;

  logic       pd_flag, pd_flag_next;
  logic       v_flag, v_flag_next;
  logic       h_flag, h_flag_next;
  logic [1:0] disp_mode, disp_mode_next;
  logic [6:0] col_counter, col_counter_next;
  logic [2:0] bank_counter, bank_counter_next;
  logic [1:0] tc_value, tc_value_next;
  logic [2:0] bias_value, bias_value_next;
  logic [6:0] vop_value, vop_value_next;
  logic       ign;
  logic [6:0] col_inc;
  logic [2:0] bank_inc;
  logic       col_wrap, bank_wrap;

  assign col_wrap  = (col_counter == COL_LAST);
  assign bank_wrap = (bank_counter == BANK_LAST);
  assign col_inc   = col_wrap ? 7'd0 : col_counter + 7'd1;
  assign bank_inc  = bank_wrap ? 3'd0 : bank_counter + 3'd1;

  always_comb begin
    pd_flag_next      = pd_flag;
    v_flag_next       = v_flag;
    h_flag_next       = h_flag;
    disp_mode_next    = disp_mode;
    col_counter_next  = col_counter;
    bank_counter_next = bank_counter;
    tc_value_next     = tc_value;
    bias_value_next   = bias_value;
    vop_value_next    = vop_value;
    ign               = 1'b0;
    if (operation) begin
      if (v_flag) begin
        bank_counter_next = bank_inc;
        if (bank_wrap) begin
          col_counter_next = col_inc;
        end
      end else begin
        col_counter_next = col_inc;
        if (col_wrap) begin
          bank_counter_next = bank_inc;
        end
      end
    end else begin
      case (cmd_class(frame_byte))
        CMD_NOP: begin
          ign = 1'b0;
        end
        CMD_FUNC: begin
          pd_flag_next = frame_byte[2];
          v_flag_next  = frame_byte[1];
          h_flag_next  = frame_byte[0];
        end
        CMD_DISP: begin
          if (h_flag) begin
            ign = 1'b1;
          end else begin
            disp_mode_next = {frame_byte[0], frame_byte[2]};
          end
        end
        CMD_YADDR: begin
          if (h_flag || (frame_byte[5:0] >= BANK_LIMIT)) begin
            ign = 1'b1;
          end else begin
            bank_counter_next = frame_byte[2:0];
          end
        end
        CMD_XADDR: begin
          if (h_flag) begin
            vop_value_next = frame_byte[6:0];
          end else if ({1'b0, frame_byte[6:0]} >= COL_LIMIT) begin
            ign = 1'b1;
          end else begin
            col_counter_next = frame_byte[6:0];
          end
        end
        CMD_TEMP: begin
          if (!h_flag) begin
            ign = 1'b1;
          end else begin
            tc_value_next = frame_byte[1:0];
          end
        end
        CMD_BIAS: begin
          if (!h_flag) begin
            ign = 1'b1;
          end else begin
            bias_value_next = frame_byte[2:0];
          end
        end
        default: begin
          ign = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res.ram_write         = operation;
    res.ram_column        = operation ? col_counter : 7'd0;
    res.ram_bank          = operation ? bank_counter : 3'd0;
    res.ram_data          = operation ? frame_byte : 8'd0;
    res.powered_down      = pd_flag_next;
    res.vertical_mode     = v_flag_next;
    res.extended_set      = h_flag_next;
    res.display_mode      = disp_mode_next;
    res.temp_coeff        = tc_value_next;
    res.bias_level        = bias_value_next;
    res.operating_voltage = vop_value_next;
    res.ignored           = ign;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_flag      <= 1'b1;
      v_flag       <= 1'b0;
      h_flag       <= 1'b0;
      disp_mode    <= 2'd0;
      col_counter  <= 7'd0;
      bank_counter <= 3'd0;
      tc_value     <= 2'd0;
      bias_value   <= 3'd0;
      vop_value    <= 7'd0;
    end else if (fire) begin
      pd_flag      <= pd_flag_next;
      v_flag       <= v_flag_next;
      h_flag       <= h_flag_next;
      disp_mode    <= disp_mode_next;
      col_counter  <= col_counter_next;
      bank_counter <= bank_counter_next;
      tc_value     <= tc_value_next;
      bias_value   <= bias_value_next;
      vop_value    <= vop_value_next;
    end
  end

endmodule

FILE: design/lcdcd_output_stage.sv
// Result register holding one decoded beat until the sink takes it.
module lcdcd_output_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  output logic               load_ready,
  input  lcdcd_pkg::result_t load_res,
  lcdcd_out_if.source        res_out
);
  import lcdcd_pkg::*;

  logic    valid;
  result_t res;

  assign load_ready = !valid || res_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res <= load_res;
    end
  end

  assign res_out.valid             = valid;
  assign res_out.ram_write         = res.ram_write;
  assign res_out.ram_column        = res.ram_column;
  assign res_out.ram_bank          = res.ram_bank;
  assign res_out.ram_data          = res.ram_data;
  assign res_out.powered_down      = res.powered_down;
  assign res_out.vertical_mode     = res.vertical_mode;
  assign res_out.extended_set      = res.extended_set;
  assign res_out.display_mode      = res.display_mode;
  assign res_out.temp_coeff        = res.temp_coeff;
  assign res_out.bias_level        = res.bias_level;
  assign res_out.operating_voltage = res.operating_voltage;
  assign res_out.ignored           = res.ignored;

endmodule

FILE: design/lcdcd_output_stage_wrap_note.sv
// Input register capturing one SPI frame beat ahead of the decode logic.
module lcdcd_input_stage (
  input  logic        clk,
  input  logic        rst,
  lcdcd_in_if.sink    cmd_in,
  output logic        valid,
  input  logic        take,
  output logic        operation,
  output logic [7:0]  frame_byte
);
  assign cmd_in.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd_in.ready) begin
      valid <= cmd_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.valid && cmd_in.ready) begin
      operation  <= cmd_in.operation;
      frame_byte <= cmd_in.frame_byte;
    end
  end

endmodule
